[hdl/rhc_pkg.sv]
// ----------------------------------------------------------------------------
// rhc_pkg
// Types and constants shared by the RGB to HSV converter modules.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int RemW   = 36;   // dividend / remainder width
    localparam int DivW   = 20;   // divisor width
    localparam int QuoW   = 16;   // quotient width
    localparam int NLanes = 3;    // hue, saturation, brightness

    localparam logic [1:0] FmtFull8  = 2'd0;
    localparam logic [1:0] FmtDeg8   = 2'd1;
    localparam logic [1:0] FmtFull16 = 2'd2;
    localparam logic [1:0] FmtUnused = 2'd3;   // behaves as FmtFull8

    localparam int LaneHue = 0;
    localparam int LaneSat = 1;
    localparam int LaneVal = 2;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pix_in_t;

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] saturation;
        logic [15:0] brightness;
    } pix_out_t;

    // one division in flight
    typedef struct packed {
        logic [RemW-1:0] rem;
        logic [DivW-1:0] div;
        logic [QuoW-1:0] quo;
    } lane_t;

endpackage

[hdl/rhc_front.sv]
// ----------------------------------------------------------------------------
// rhc_front
// Clamp, max/min, sector position, then dividends and divisors for the
// hue and saturation divisions; brightness is scaled here. Two register stages.
// ----------------------------------------------------------------------------
module rhc_front import rhc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [1:0]  fmt,
    input  logic        in_valid,
    input  pix_in_t     in_pix,
    output logic        out_valid,
    output lane_t       out_lanes [NLanes]
);

    logic        valid_a_reg;
    logic [15:0] top_a_reg, rng_a_reg, maxsv_a_reg;
    logic [18:0] pos_a_reg;
    logic        deg_a_reg;
    logic        valid_b_reg;
    lane_t       lanes_b_reg [NLanes];

    logic [15:0] r, g, b, top, bot, rng, maxsv;
    logic [18:0] pos;
    logic        deg, is8;
    logic [15:0] vscaled, bright;

    always_comb begin
        deg    = (fmt == FmtDeg8);
        is8    = (fmt != FmtFull16);
        maxsv  = deg ? 16'd100 : (is8 ? 16'd255 : 16'd65535);
        r = (is8 && in_pix.red   > 16'd255) ? 16'd255 : in_pix.red;
        g = (is8 && in_pix.green > 16'd255) ? 16'd255 : in_pix.green;
        b = (is8 && in_pix.blue  > 16'd255) ? 16'd255 : in_pix.blue;
        top = r;
        if (g > top) top = g;
        if (b > top) top = b;
        bot = r;
        if (g < bot) bot = g;
        if (b < bot) bot = b;
        rng = top - bot;
        // first matching (top, bottom) pair picks the sector
        if (top == r && bot == b) begin
            pos = 19'(g - bot);
        end else if (top == g && bot == b) begin
            pos = 19'(top - r) + 19'(rng);
        end else if (top == g && bot == r) begin
            pos = 19'(b - bot) + 19'(rng) * 19'd2;
        end else if (top == b && bot == r) begin
            pos = 19'(top - g) + 19'(rng) * 19'd3;
        end else if (top == b && bot == g) begin
            pos = 19'(r - bot) + 19'(rng) * 19'd4;
        end else begin
            pos = 19'(top - b) + 19'(rng) * 19'd5;
        end
    end

    // brightness: rounding to full scale gives top back unchanged;
    // percent needs (top * 100 + 127) / 255, done as a reciprocal
    always_comb begin
        vscaled = 16'(top_a_reg * 16'd100) + 16'd127;
        bright  = deg_a_reg ? 16'((vscaled + (vscaled >> 8) + 16'd1) >> 8) : top_a_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else if (en) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            top_a_reg    <= top;
            rng_a_reg    <= rng;
            pos_a_reg    <= pos;
            deg_a_reg    <= deg;
            maxsv_a_reg  <= maxsv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (rng_a_reg == 16'd0) begin
                // grey: force zero hue and saturation, keep divisors nonzero
                lanes_b_reg[LaneHue].rem <= '0;
                lanes_b_reg[LaneHue].div <= DivW'(6);
                lanes_b_reg[LaneSat].rem <= '0;
                lanes_b_reg[LaneSat].div <= DivW'(1);
            end else begin
                lanes_b_reg[LaneHue].rem <= deg_a_reg
                    ? RemW'(RemW'(pos_a_reg) * RemW'(360))
                    : RemW'(pos_a_reg) << 16;
                lanes_b_reg[LaneHue].div <= DivW'(rng_a_reg) * DivW'(6);
                lanes_b_reg[LaneSat].rem <= RemW'(32'(rng_a_reg) * 32'(maxsv_a_reg))
                    + RemW'(top_a_reg >> 1);
                lanes_b_reg[LaneSat].div <= DivW'(top_a_reg);
            end
            lanes_b_reg[LaneHue].quo <= '0;
            lanes_b_reg[LaneSat].quo <= '0;
            // finished value rides the chain: zero remainder never subtracts
            lanes_b_reg[LaneVal].rem <= '0;
            lanes_b_reg[LaneVal].div <= DivW'(1);
            lanes_b_reg[LaneVal].quo <= bright;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_lanes = lanes_b_reg;

endmodule

[hdl/rhc_div_cell.sv]
// ----------------------------------------------------------------------------
// rhc_div_cell
// One restoring-division step for each lane: settles quotient bit STEP.
// ----------------------------------------------------------------------------
module rhc_div_cell import rhc_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  lane_t  in_lanes  [NLanes],
    output logic   out_valid,
    output lane_t  out_lanes [NLanes]
);

    logic  valid_reg;
    lane_t lanes_reg  [NLanes];
    lane_t lanes_next [NLanes];

    always_comb begin
        for (int i = 0; i < NLanes; i++) begin
            lanes_next[i] = in_lanes[i];
            if (in_lanes[i].rem >= (RemW'(in_lanes[i].div) << STEP)) begin
                lanes_next[i].rem = in_lanes[i].rem - (RemW'(in_lanes[i].div) << STEP);
                lanes_next[i].quo = in_lanes[i].quo | (QuoW'(1) << STEP);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;

endmodule

[hdl/rgb_to_hsv_converter_top.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// RGB pixel in, integer hue / saturation / brightness out.
// ----------------------------------------------------------------------------
// Input word s_data (red, green, blue) is taken when s_valid and s_ready are
// high; the result word m_data (hue, saturation, brightness) leaves when
// m_valid and m_ready are high. cfg_we writes cfg_wdata into the format
// register (0: 16-bit hue, 8-bit S/V; 1: degrees / percent; 2: all 16-bit);
// write it only while no pixel is in flight.
// There are two prep stages, then a chain of 16 divider cells,
// one quotient bit per cell, for the hue and saturation divisions;
// brightness is scaled in the prep stages and rides along the chain.
// Throughput is one pixel per cycle unless the receiver stalls. The whole
// pipeline moves on a common enable, so when the receiver stalls with a word at
// the output every stage holds and s_ready drops in the same cycle.
// Reset clears all valid flags and sets the format to 0.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top import rhc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  pix_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output pix_out_t   m_data
);

    logic [1:0] fmt_reg;
    logic       en;
    logic       valid_s [QuoW+1];
    lane_t      lanes_s [QuoW+1][NLanes];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FmtFull8;
        end else if (cfg_we) begin
            fmt_reg <= cfg_wdata;
        end
    end

    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    rhc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .fmt       (fmt_reg),
        .in_valid  (s_valid),
        .in_pix    (s_data),
        .out_valid (valid_s[0]),
        .out_lanes (lanes_s[0])
    );

    // cell k settles quotient bit QuoW-1-k
    for (genvar k = 0; k < QuoW; k++) begin : g_cell
        rhc_div_cell #(.STEP(QuoW - 1 - k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (valid_s[k]),
            .in_lanes  (lanes_s[k]),
            .out_valid (valid_s[k+1]),
            .out_lanes (lanes_s[k+1])
        );
    end

    assign m_valid           = valid_s[QuoW];
    assign m_data.hue        = lanes_s[QuoW][LaneHue].quo;
    assign m_data.saturation = lanes_s[QuoW][LaneSat].quo;
    assign m_data.brightness = lanes_s[QuoW][LaneVal].quo;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB to HSV converter: directed table, then per
// format the table again and random pixels, compared with an in-bench color model.
// ----------------------------------------------------------------------------
module testbench import rhc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency  = 18;
    localparam int CycLimit = 200000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     cfg_we = 1'b0;
    logic [1:0] cfg_wdata = '0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pix_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pix_out_t m_data;

    pix_out_t hsv_queue[$];
    logic [1:0] fmt_now;
    int       errors = 0;
    int       cycles = 0;
    bit       rx_quiet = 1'b0;   // no stall stretch
    bit       rx_hold = 1'b0;    // long stall request
    bit       tx_quiet = 1'b0;
    logic [1:0] fmts[5] = '{FmtFull8, FmtDeg8, FmtFull16, FmtUnused, FmtFull16};

    typedef struct {
        logic [15:0] r, g, b;
        bit          chk;        // typed-in result valid
        logic [15:0] h, s, v;
    } dir_row_t;

    rgb_to_hsv_converter_top i_dut (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycLimit) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic pix_out_t rgb_to_hsv(pix_in_t p, logic [1:0] fmt);
        logic [63:0] r, g, b, wrap, maxsv, maxrgb, top, bot, rng, pos;
        pix_out_t o;
        r = p.red; g = p.green; b = p.blue;
        if (fmt == FmtDeg8) begin
            wrap = 360; maxsv = 100; maxrgb = 255;
        end else if (fmt == FmtFull16) begin
            wrap = 65536; maxsv = 65535; maxrgb = 65535;
        end else begin
            wrap = 65536; maxsv = 255; maxrgb = 255;
        end
        if (maxrgb == 255) begin
            if (r > 255) r = 255;
            if (g > 255) g = 255;
            if (b > 255) b = 255;
        end
        top = r; bot = r;
        if (g > top) top = g;
        if (b > top) top = b;
        if (g < bot) bot = g;
        if (b < bot) bot = b;
        rng = top - bot;
        o.brightness = 16'((top * maxsv + maxrgb / 2) / maxrgb);
        o.hue = '0;
        o.saturation = '0;
        if (rng != 0) begin
            if (top == r && bot == b)      pos = g - bot;
            else if (top == g && bot == b) pos = (top - r) + rng;
            else if (top == g && bot == r) pos = (b - bot) + rng * 2;
            else if (top == b && bot == r) pos = (top - g) + rng * 3;
            else if (top == b && bot == g) pos = (r - bot) + rng * 4;
            else                           pos = (top - b) + rng * 5;
            o.hue = 16'(pos * wrap / (rng * 6));
            o.saturation = 16'((rng * maxsv + top / 2) / top);
        end
        return o;
    endfunction

    // result side: random stalls, plus an optional long hold-off
    always @(posedge aclk) begin
        if (rx_hold) m_ready <= 1'b0;
        else if (rx_quiet) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 24);
    end

    always @(posedge aclk) begin
        pix_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (hsv_queue.size() == 0) begin
                $display("%t unexpected word: got %h", $realtime, m_data);
                errors++;
            end else begin
                want = hsv_queue.pop_front();
                if (m_data.hue !== want.hue) begin
                    $display("%t hue: exp %0d got %0d", $realtime, want.hue, m_data.hue);
                    errors++;
                end
                if (m_data.saturation !== want.saturation) begin
                    $display("%t sat: exp %0d got %0d", $realtime,
                             want.saturation, m_data.saturation);
                    errors++;
                end
                if (m_data.brightness !== want.brightness) begin
                    $display("%t val: exp %0d got %0d", $realtime,
                             want.brightness, m_data.brightness);
                    errors++;
                end
            end
        end
    end

    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        pix_in_t p;
        p.red = r; p.green = g; p.blue = b;
        while (!tx_quiet && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        hsv_queue.push_back(rgb_to_hsv(p, fmt_now));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_and_set(logic [1:0] fmt);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (hsv_queue.size() != 0) @(posedge aclk);
        repeat (Latency + 4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= fmt;
        @(posedge aclk);
        cfg_we <= 1'b0;
        fmt_now = fmt;
    endtask

    task automatic random_pixel(logic [1:0] fmt);
        logic [15:0] c[3];
        int mode;
        mode = $urandom_range(9);
        for (int k = 0; k < 3; k++) begin
            if (fmt == FmtFull16 || mode == 0) c[k] = 16'($urandom);
            else c[k] = 16'($urandom_range(255));
        end
        if (mode == 1) c[1] = c[0];           // ties
        if (mode == 2) begin
            c[1] = c[0]; c[2] = c[0];          // grey
        end
        send_pixel(c[0], c[1], c[2]);
    endtask

    dir_row_t dir_tab[14] = '{
        '{16'd0,     16'd0,     16'd0,     1, 16'd0,     16'd0,   16'd0},
        '{16'd255,   16'd255,   16'd255,   1, 16'd0,     16'd0,   16'd255},
        '{16'd255,   16'd0,     16'd0,     1, 16'd0,     16'd255, 16'd255},
        '{16'd0,     16'd255,   16'd0,     0, 0, 0, 0},
        '{16'd0,     16'd0,     16'd255,   0, 0, 0, 0},
        '{16'd255,   16'd255,   16'd0,     0, 0, 0, 0},
        '{16'd0,     16'd255,   16'd255,   0, 0, 0, 0},
        '{16'd255,   16'd0,     16'd255,   0, 0, 0, 0},
        '{16'd200,   16'd100,   16'd50,    0, 0, 0, 0},
        '{16'd50,    16'd200,   16'd100,   0, 0, 0, 0},
        '{16'd100,   16'd50,    16'd200,   0, 0, 0, 0},
        '{16'd65535, 16'd65535, 16'd65535, 1, 16'd0,     16'd0,   16'd255},
        '{16'd65535, 16'd300,   16'd0,     0, 0, 0, 0},
        '{16'd1,     16'd0,     16'd0,     0, 0, 0, 0}
    };

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        fmt_now = FmtFull8;
        @(posedge aclk);
        // after-reset format, directed table
        foreach (dir_tab[i]) begin
            send_pixel(dir_tab[i].r, dir_tab[i].g, dir_tab[i].b);
            if (dir_tab[i].chk) begin
                hsv_queue[$].hue = dir_tab[i].h;
                hsv_queue[$].saturation = dir_tab[i].s;
                hsv_queue[$].brightness = dir_tab[i].v;
            end
        end
        foreach (fmts[f]) begin
            drain_and_set(fmts[f]);
            foreach (dir_tab[i]) send_pixel(dir_tab[i].r, dir_tab[i].g, dir_tab[i].b);
            tx_quiet = (f == 1);
            rx_quiet = (f == 1);
            for (int n = 0; n < 75; n++) begin
                if (f == 2 && n == 10) begin
                    fork
                        begin
                            rx_hold = 1'b1;
                            repeat (60) @(posedge aclk);
                            rx_hold = 1'b0;
                        end
                    join_none
                end
                random_pixel(fmts[f]);
            end
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
        end
        s_valid <= 1'b0;
        while (hsv_queue.size() != 0) @(posedge aclk);
        repeat (Latency + 4) @(posedge aclk);
        if (errors == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end
endmodule

[sim.f]
hdl/rhc_pkg.sv
hdl/rhc_front.sv
hdl/rhc_div_cell.sv
hdl/rgb_to_hsv_converter_top.sv
tb/testbench.sv
